FILE: rtl/core/ecs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecs_pkg: shared types and constants of the crossfade selector
// Sizes, job record, queue status, back-end states and the gain table.
// ----------------------------------------------------------------------------
package ecs_pkg;

	localparam int MAX_CHANNELS    = 64;
	localparam int SAMPLE_BITS     = 24;
	localparam int GAIN_TABLE_BITS = 10;

	localparam int CH_BITS  = $clog2(MAX_CHANNELS);
	localparam int CNT_BITS = 7;
	localparam int LEN_BITS = 20;
	localparam int REM_BITS = LEN_BITS + 1;

	localparam int K_BITS       = GAIN_TABLE_BITS + 1;
	localparam int GAIN_ENTRIES = (1 << GAIN_TABLE_BITS) + 1;
	localparam int GAIN_BITS    = 31;
	localparam int GAIN_FRAC    = 30;
	localparam int PROD_BITS    = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int SUM_BITS     = PROD_BITS + 1;
	localparam int DIV_STEPS    = K_BITS;
	localparam int STEP_BITS    = $clog2(DIV_STEPS);

	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

	localparam logic [CNT_BITS-1:0] CHANNEL_COUNT_RESET = CNT_BITS'(8);
	localparam logic [LEN_BITS-1:0] FADE_LENGTH_RESET   = LEN_BITS'(2205);
	localparam logic [CNT_BITS-1:0] MIN_COUNT           = CNT_BITS'(2);
	localparam logic [CNT_BITS-1:0] MAX_COUNT           = CNT_BITS'(MAX_CHANNELS);

	// register indexes
	localparam logic REG_CHANNEL_COUNT = 1'b0;
	localparam logic REG_FADE_LENGTH   = 1'b1;

	// command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	localparam logic [63:0] PI_OVER_TWO_Q30 = 64'd1686629713;
	localparam logic [7:0]  TAYLOR_DIV [6]  = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] cur;
		logic signed [SAMPLE_BITS-1:0] prev;
		logic                          fade;
		logic [LEN_BITS-1:0]           done;
		logic [LEN_BITS-1:0]           len;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_ROM,
		BK_MUL,
		BK_SUM,
		BK_OUT
	} back_state_t;

	typedef logic [GAIN_BITS-1:0] gain_rom_t [GAIN_ENTRIES];

	// sine of k/2^G * pi/2 in Q30, Taylor series to the 13th power
	function automatic gain_rom_t gain_table();
		gain_rom_t   tbl;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] s;
		logic [63:0] t;
		for (int k = 0; k < GAIN_ENTRIES; k++) begin
			x  = (64'(k) * PI_OVER_TWO_Q30) >> GAIN_TABLE_BITS;
			x2 = (x * x) >> GAIN_FRAC;
			s  = x;
			t  = x;
			for (int j = 0; j < 6; j++) begin
				t = ((t * x2) >> GAIN_FRAC) / 64'(TAYLOR_DIV[j]);
				if ((j % 2) == 0) begin
					s = (s >= t) ? s - t : 64'd0;
				end else begin
					s = s + t;
				end
			end
			if (s > (64'd1 << GAIN_FRAC)) begin
				s = 64'd1 << GAIN_FRAC;
			end
			tbl[k] = s[GAIN_BITS-1:0];
		end
		return tbl;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ecs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecs_if: channel interfaces of the crossfade selector
// Sample/command channel into the block and mixed-sample channel out of it.
// ----------------------------------------------------------------------------
interface ecs_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  command;
	logic [ecs_pkg::CH_BITS-1:0]           channel;
	logic signed [ecs_pkg::SAMPLE_BITS-1:0] sample;
	logic                                  frame_end;

	modport source (output valid, command, channel, sample, frame_end, input ready);
	modport sink (input valid, command, channel, sample, frame_end, output ready);
endinterface

interface ecs_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [ecs_pkg::SAMPLE_BITS-1:0] mixed_sample;
	logic                                  fading;

	modport source (output valid, mixed_sample, fading, input ready);
	modport sink (input valid, mixed_sample, fading, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ecs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecs_front: transaction intake and channel tracking
// Handles selects and sample latching, keeps the fade counter and queues
// one mix job per frame end.
// ----------------------------------------------------------------------------
module ecs_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	ecs_in_if.sink                           audio,
	input  wire logic                        cfg_wr_en,
	input  wire logic                        cfg_index,
	input  wire logic [ecs_pkg::LEN_BITS-1:0] cfg_data,
	input  wire ecs_pkg::queue_status_t      q_status,
	output logic                             push,
	output ecs_pkg::job_t                    push_job
);

	logic [ecs_pkg::CNT_BITS-1:0]           channel_count_q;
	logic [ecs_pkg::LEN_BITS-1:0]           fade_length_q;
	logic [ecs_pkg::CH_BITS-1:0]            cur_ch_q;
	logic [ecs_pkg::CH_BITS-1:0]            prev_ch_q;
	logic signed [ecs_pkg::REM_BITS-1:0]    remaining_q;
	logic signed [ecs_pkg::SAMPLE_BITS-1:0] cur_smp_q;
	logic signed [ecs_pkg::SAMPLE_BITS-1:0] prev_smp_q;

	logic                                   accept;
	logic [ecs_pkg::CNT_BITS-1:0]           eff_count;
	logic                                   sel_ok;
	logic                                   hit_cur;
	logic                                   hit_prev;
	logic [ecs_pkg::LEN_BITS-1:0]           len_eff;
	logic [ecs_pkg::LEN_BITS-1:0]           rem_clamp;

	assign audio.ready = !q_status.full;
	assign accept      = audio.valid && audio.ready;

	always_comb begin
		if (channel_count_q < ecs_pkg::MIN_COUNT) begin
			eff_count = ecs_pkg::MIN_COUNT;
		end else if (channel_count_q > ecs_pkg::MAX_COUNT) begin
			eff_count = ecs_pkg::MAX_COUNT;
		end else begin
			eff_count = channel_count_q;
		end
	end

	assign sel_ok   = ({1'b0, audio.channel} < eff_count) && (audio.channel != cur_ch_q);
	assign hit_cur  = audio.channel == cur_ch_q;
	assign hit_prev = audio.channel == prev_ch_q;
	assign len_eff  = (fade_length_q == '0) ? ecs_pkg::LEN_BITS'(1) : fade_length_q;

	always_comb begin
		if (remaining_q[ecs_pkg::LEN_BITS-1:0] > len_eff) begin
			rem_clamp = len_eff;
		end else begin
			rem_clamp = remaining_q[ecs_pkg::LEN_BITS-1:0];
		end
	end

	assign push = accept && (audio.command == ecs_pkg::CMD_SAMPLE) && audio.frame_end;

	always_comb begin
		push_job.cur  = hit_cur ? audio.sample : cur_smp_q;
		push_job.prev = hit_prev ? audio.sample : prev_smp_q;
		push_job.fade = !remaining_q[ecs_pkg::REM_BITS-1];
		push_job.done = len_eff - rem_clamp;
		push_job.len  = len_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= ecs_pkg::CHANNEL_COUNT_RESET;
			fade_length_q   <= ecs_pkg::FADE_LENGTH_RESET;
			cur_ch_q        <= '0;
			prev_ch_q       <= '0;
			remaining_q     <= '0;
			cur_smp_q       <= '0;
			prev_smp_q      <= '0;
		end else begin
			if (accept) begin
				if (audio.command == ecs_pkg::CMD_SELECT) begin
					if (sel_ok) begin
						prev_ch_q   <= cur_ch_q;
						prev_smp_q  <= cur_smp_q;
						cur_ch_q    <= audio.channel;
						remaining_q <= {1'b0, len_eff};
					end
				end else begin
					if (hit_cur) begin
						cur_smp_q <= audio.sample;
					end
					if (hit_prev) begin
						prev_smp_q <= audio.sample;
					end
					if (audio.frame_end && !remaining_q[ecs_pkg::REM_BITS-1]) begin
						remaining_q <= remaining_q - ecs_pkg::REM_BITS'(1);
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					ecs_pkg::REG_CHANNEL_COUNT: begin
						channel_count_q <= cfg_data[ecs_pkg::CNT_BITS-1:0];
					end
					ecs_pkg::REG_FADE_LENGTH: begin
						fade_length_q <= cfg_data;
						remaining_q   <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/ecs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecs_queue: job queue between front and back end
// Two-entry first-in first-out store of mix jobs.
// ----------------------------------------------------------------------------
module ecs_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire ecs_pkg::job_t          push_job,
	input  wire logic                   pop,
	output ecs_pkg::job_t               head_job,
	output ecs_pkg::queue_status_t      status
);

	ecs_pkg::job_t                       entry_q [ecs_pkg::QUEUE_DEPTH];
	logic [ecs_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [ecs_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [ecs_pkg::QUEUE_CNT_BITS-1:0] count_q;
	logic                               do_push;
	logic                               do_pop;

	assign status.full  = count_q == ecs_pkg::QUEUE_CNT_BITS'(ecs_pkg::QUEUE_DEPTH);
	assign status.empty = count_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head_job     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + ecs_pkg::QUEUE_PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + ecs_pkg::QUEUE_PTR_BITS'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + ecs_pkg::QUEUE_CNT_BITS'(1);
				2'b01:   count_q <= count_q - ecs_pkg::QUEUE_CNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/ecs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecs_back: crossfade mix engine
// Divides out the fade phase, looks up both gains, mixes, rounds and
// saturates if fading, then holds the result until the transaction completes.
// ----------------------------------------------------------------------------
module ecs_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ecs_pkg::job_t          head_job,
	input  wire ecs_pkg::queue_status_t q_status,
	output logic                        pop,
	ecs_out_if.source                   result
);

	localparam ecs_pkg::gain_rom_t GAIN_ROM = ecs_pkg::gain_table();
	localparam logic [ecs_pkg::K_BITS-1:0] K_FULL = ecs_pkg::K_BITS'(1 << ecs_pkg::GAIN_TABLE_BITS);

	ecs_pkg::back_state_t                   state_q;
	ecs_pkg::back_state_t                   state_nxt;

	logic signed [ecs_pkg::SAMPLE_BITS-1:0] cur_q;
	logic signed [ecs_pkg::SAMPLE_BITS-1:0] prev_q;
	logic [ecs_pkg::LEN_BITS-1:0]           len_q;
	logic [ecs_pkg::REM_BITS-1:0]           rem_q;
	logic [ecs_pkg::K_BITS-1:0]             k_q;
	logic [ecs_pkg::STEP_BITS-1:0]          step_q;
	logic [ecs_pkg::GAIN_BITS-1:0]          gs_q;
	logic [ecs_pkg::GAIN_BITS-1:0]          gc_q;
	logic signed [ecs_pkg::PROD_BITS-1:0]   prod_cur_q;
	logic signed [ecs_pkg::PROD_BITS-1:0]   prod_prev_q;
	logic signed [ecs_pkg::SAMPLE_BITS-1:0] mix_q;
	logic                                   fading_q;

	logic                                   div_ge;
	logic [ecs_pkg::REM_BITS-1:0]           rem_sub;
	logic signed [ecs_pkg::SUM_BITS-1:0]    sum;
	logic signed [ecs_pkg::SUM_BITS-ecs_pkg::GAIN_FRAC-1:0] rounded;
	logic signed [ecs_pkg::SAMPLE_BITS-1:0] sat;

	localparam logic signed [ecs_pkg::SUM_BITS-ecs_pkg::GAIN_FRAC-1:0] SAT_HI =
		(ecs_pkg::SUM_BITS-ecs_pkg::GAIN_FRAC)'((1 << (ecs_pkg::SAMPLE_BITS - 1)) - 1);
	localparam logic signed [ecs_pkg::SUM_BITS-ecs_pkg::GAIN_FRAC-1:0] SAT_LO =
		-(ecs_pkg::SUM_BITS-ecs_pkg::GAIN_FRAC)'(1 << (ecs_pkg::SAMPLE_BITS - 1));

	// restoring divide, one quotient bit per cycle
	assign div_ge  = rem_q >= {1'b0, len_q};
	assign rem_sub = div_ge ? rem_q - {1'b0, len_q} : rem_q;

	// round half up then clamp
	assign sum     = ecs_pkg::SUM_BITS'(prod_cur_q) + ecs_pkg::SUM_BITS'(prod_prev_q)
		+ ecs_pkg::SUM_BITS'(64'd1 << (ecs_pkg::GAIN_FRAC - 1));
	assign rounded = sum[ecs_pkg::SUM_BITS-1:ecs_pkg::GAIN_FRAC];

	always_comb begin
		if (rounded > SAT_HI) begin
			sat = SAT_HI[ecs_pkg::SAMPLE_BITS-1:0];
		end else if (rounded < SAT_LO) begin
			sat = SAT_LO[ecs_pkg::SAMPLE_BITS-1:0];
		end else begin
			sat = rounded[ecs_pkg::SAMPLE_BITS-1:0];
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ecs_pkg::BK_IDLE: begin
				if (!q_status.empty) begin
					state_nxt = head_job.fade ? ecs_pkg::BK_DIV : ecs_pkg::BK_OUT;
				end
			end
			ecs_pkg::BK_DIV: begin
				if (step_q == ecs_pkg::STEP_BITS'(ecs_pkg::DIV_STEPS - 1)) begin
					state_nxt = ecs_pkg::BK_ROM;
				end
			end
			ecs_pkg::BK_ROM: state_nxt = ecs_pkg::BK_MUL;
			ecs_pkg::BK_MUL: state_nxt = ecs_pkg::BK_SUM;
			ecs_pkg::BK_SUM: state_nxt = ecs_pkg::BK_OUT;
			ecs_pkg::BK_OUT: begin
				if (result.ready) begin
					state_nxt = ecs_pkg::BK_IDLE;
				end
			end
			default: state_nxt = ecs_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop                 = 1'b0;
		result.valid        = 1'b0;
		result.mixed_sample = mix_q;
		result.fading       = fading_q;
		case (state_q)
			ecs_pkg::BK_IDLE: pop = !q_status.empty;
			ecs_pkg::BK_OUT:  result.valid = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ecs_pkg::BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ecs_pkg::BK_IDLE: begin
				cur_q    <= head_job.cur;
				prev_q   <= head_job.prev;
				len_q    <= head_job.len;
				rem_q    <= {1'b0, head_job.done};
				step_q   <= '0;
				fading_q <= head_job.fade;
				mix_q    <= head_job.cur;
			end
			ecs_pkg::BK_DIV: begin
				k_q    <= {k_q[ecs_pkg::K_BITS-2:0], div_ge};
				rem_q  <= {rem_sub[ecs_pkg::REM_BITS-2:0], 1'b0};
				step_q <= step_q + ecs_pkg::STEP_BITS'(1);
			end
			ecs_pkg::BK_ROM: begin
				gs_q <= GAIN_ROM[k_q];
				gc_q <= GAIN_ROM[K_FULL - k_q];
			end
			ecs_pkg::BK_MUL: begin
				prod_cur_q  <= ecs_pkg::PROD_BITS'(cur_q * $signed({1'b0, gs_q}));
				prod_prev_q <= ecs_pkg::PROD_BITS'(prev_q * $signed({1'b0, gc_q}));
			end
			ecs_pkg::BK_SUM: begin
				mix_q <= sat;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/equal_power_crossfade_selector_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// equal_power_crossfade_selector_core: audio channel switch with crossfade
//
// audio carries one transaction per channel sample or select command; a
// sample transaction with frame_end set closes the frame and produces one
// transaction on result. A select names the new current channel and starts
// an equal-power crossfade of fade_length frames from the old one.
// The front end takes one transaction per cycle while its two-entry job
// queue has room, so sample transactions flow back to back. For each frame
// end the mix engine takes the job and, while fading, runs the phase divide,
// gain lookup, multiply and round before it presents the result; otherwise
// it presents the current sample directly. It takes no new job until the
// result transaction completes, so the mix engine sets the rate of frame
// ends. A stalled result holds in the output register; the queue then fills
// and audio.ready drops. Reset clears the channel state and fade counter and
// loads channel_count 8, fade_length 2205. The user is to write registers
// through cfg_wr_en/cfg_index/cfg_data only while idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module equal_power_crossfade_selector_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	ecs_in_if.sink                           audio,
	ecs_out_if.source                        result,
	input  wire logic                        cfg_wr_en,
	input  wire logic                        cfg_index,
	input  wire logic [ecs_pkg::LEN_BITS-1:0] cfg_data
);

	logic                   push;
	logic                   pop;
	ecs_pkg::job_t          push_job;
	ecs_pkg::job_t          head_job;
	ecs_pkg::queue_status_t q_status;

	ecs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.audio    (audio),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_status (q_status),
		.push     (push),
		.push_job (push_job)
	);

	ecs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head_job(head_job),
		.status  (q_status)
	);

	ecs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head_job(head_job),
		.q_status(q_status),
		.pop     (pop),
		.result  (result)
	);

endmodule
`default_nettype wire
